// ----- hw/rtl/integer_set_sorter_defines.svh -----
// Assertion macros for the integer set sorter.
// Used by the top level; depends on nothing else.
`ifndef INTEGER_SET_SORTER_DEFINES_SVH
`define INTEGER_SET_SORTER_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define ISS_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that, once seen, must be followed by another in the next cycle.
`define ISS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/iss_pkg.sv -----
// Shared types and constants of the integer set sorter.
// Used by every module of the block; depends on nothing.
`default_nettype none
package iss_pkg;

    localparam int MAX_COUNT = 64;
    localparam int CNT_W     = $clog2(MAX_COUNT + 1);

    typedef struct packed {
        logic signed [31:0] value;
        logic               last;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] sorted_value;
        logic               final_res;
        logic               overflow;
    } t_out_word;

    typedef struct packed {
        logic               vld;
        logic signed [31:0] val;
    } t_slot;

    typedef struct packed {
        logic busy;
        logic spill;
    } t_chain_sts;

endpackage
`default_nettype wire

// ----- hw/rtl/iss_cell.sv -----
// One cell of the insertion chain: keeps the smaller value, passes the larger on.
// Depends on iss_pkg.
`default_nettype none
module iss_cell
    import iss_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_shift,
    input  wire t_slot i_carry,
    input  wire t_slot i_right,
    output t_slot      o_held,
    output t_slot      o_carry
);

    t_slot r_held;
    t_slot r_carry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held.vld  <= 1'b0;
            r_carry.vld <= 1'b0;
        end else if (i_shift) begin
            r_held      <= i_right;
            r_carry.vld <= 1'b0;
        end else if (i_carry.vld) begin
            if (!r_held.vld) begin
                r_held      <= i_carry;
                r_carry.vld <= 1'b0;
            end else if (i_carry.val < r_held.val) begin
                r_held  <= i_carry;
                r_carry <= r_held;
            end else begin
                r_carry <= i_carry;
            end
        end else begin
            r_carry.vld <= 1'b0;
        end
    end

    assign o_held  = r_held;
    assign o_carry = r_carry;

endmodule
`default_nettype wire

// ----- hw/rtl/iss_chain.sv -----
// Row of insertion cells holding the set in ascending order from the head.
// Depends on iss_pkg and iss_cell.
`default_nettype none
module iss_chain
    import iss_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_shift,
    input  wire t_slot i_carry,
    output t_slot      o_head,
    output t_chain_sts o_sts
);

    t_slot w_held  [MAX_COUNT];
    t_slot w_carry [MAX_COUNT + 1];

    assign w_carry[0] = i_carry;

    for (genvar g = 0; g < MAX_COUNT; g++) begin : g_cell
        t_slot w_right;
        if (g == MAX_COUNT - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_body
            assign w_right = w_held[g + 1];
        end
        iss_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (i_shift),
            .i_carry (w_carry[g]),
            .i_right (w_right),
            .o_held  (w_held[g]),
            .o_carry (w_carry[g + 1])
        );
    end

    always_comb begin
        o_sts.busy = 1'b0;
        for (int i = 1; i <= MAX_COUNT; i++) begin
            o_sts.busy = o_sts.busy | w_carry[i].vld;
        end
        o_sts.spill = w_carry[MAX_COUNT].vld;
    end

    assign o_head = w_held[0];

endmodule
`default_nettype wire

// ----- hw/rtl/integer_set_sorter.sv -----
// Integer set sorter: collects signed words and returns them in ascending order.
// Depends on iss_pkg, iss_chain and integer_set_sorter_defines.svh.
//
// The input channel takes one word per cycle while the block is filling a set;
// each word carries a value and a flag marking the last word of the set. Up to
// MAX_COUNT values are kept; further words are dropped and the overflow is
// reported on the final result word of the set. A flagged word closes the set
// even when it is dropped.
// Each accepted value enters a chain of compare-and-swap cells and ripples one
// cell per cycle, so filling runs at one word per cycle. After the last word,
// input ready falls while the chain settles, until no carry is left moving in
// it. The set then leaves from the head of the chain at one word per cycle
// unless the receiver stalls, the whole chain shifting one place each time.
// A result word sits in an output register; while the receiver stalls the
// chain holds, and a new set may start filling as soon as the final word has
// been loaded into that register.
// Reset empties the chain and the output register and leaves the block filling.
`default_nettype none
`include "integer_set_sorter_defines.svh"
module integer_set_sorter
    import iss_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_word i_in_data,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_out_word     o_out_data
);

    typedef enum logic [1:0] {
        S_FILL,
        S_SETTLE,
        S_DRAIN
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_count;
    logic             r_ovf;
    logic             r_out_vld;
    t_out_word        r_out;

    logic       w_accept;
    logic       w_store;
    logic       w_load;
    logic       w_final;
    t_slot      w_carry;
    t_slot      w_head;
    t_chain_sts w_sts;

    assign o_in_ready    = (r_state == S_FILL);
    assign w_accept      = i_in_valid && o_in_ready;
    assign w_store       = w_accept && (r_count < CNT_W'(MAX_COUNT));
    assign w_carry.vld   = w_store;
    assign w_carry.val   = i_in_data.value;
    assign w_load        = (r_state == S_DRAIN) && (!r_out_vld || i_out_ready);
    assign w_final       = (r_count == CNT_W'(1));

    iss_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (w_load),
        .i_carry (w_carry),
        .o_head  (w_head),
        .o_sts   (w_sts)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_FILL;
            r_count   <= '0;
            r_ovf     <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_FILL: begin
                    if (w_accept) begin
                        if (w_store) begin
                            r_count <= r_count + CNT_W'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_in_data.last) begin
                            r_state <= S_SETTLE;
                        end
                    end
                end
                S_SETTLE: begin
                    if (!w_sts.busy) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (w_load) begin
                        r_count <= r_count - CNT_W'(1);
                        if (w_final) begin
                            r_ovf   <= 1'b0;
                            r_state <= S_FILL;
                        end
                    end
                end
                default: begin
                    r_state <= S_FILL;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out.sorted_value <= w_head.val;
            r_out.final_res    <= w_final;
            r_out.overflow     <= w_final && r_ovf;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    `ISS_ASSERT_ALWAYS(a_no_spill, i_clk, i_rst_n, !w_sts.spill, "value ran off the chain end")
    `ISS_ASSERT_ALWAYS(a_head_full, i_clk, i_rst_n, !w_load || w_head.vld, "drained an empty cell")
    `ISS_ASSERT_NEXT(a_back_to_fill, i_clk, i_rst_n, w_load && w_final, (r_state == S_FILL) && (r_count == '0), "set did not close after its final word")

endmodule
`default_nettype wire
